// File: rtl/mmrs_pkg.sv
// Package with shared constants, controller states and command/status types.
`default_nettype none

package mmrs_pkg;

    localparam int DIM_DEFAULT = 16;
    localparam int OUT_MAX     = 16;
    localparam int IDX_BITS    = 4;
    localparam int ELEM_BITS   = 16;
    localparam int PROD_BITS   = 32;
    localparam int ACC_BITS    = 36;
    localparam int S_DATA_BITS = 24;
    localparam int M_DATA_BITS = 48;

    localparam logic REQ_LOAD_B   = 1'b0;
    localparam logic REQ_STREAM_A = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_EMIT_RD,
        ST_EMIT_LD
    } state_t;

    typedef struct packed {
        logic ready;
        logic mac_issue;
        logic emit_rd;
        logic emit_ld;
    } cmd_t;

    typedef struct packed {
        logic a_start;
        logic j_last;
        logic pipe_busy;
        logic emit_pending;
        logic out_free;
        logic emit_last;
    } status_t;

endpackage

`default_nettype wire

// File: rtl/matrix_multiply_row_stream_unit.sv
// Top level of the streaming row-by-row dense matrix multiply unit.
// B loads and A elements are accepted only in the idle state. A B load is written to the
// B store; an A element sends the single shared MAC through one B row in the MAC state, and
// the DRAIN state waits until its two-stage pipeline has written the last accumulator back.
// After the last A element of a row, min(DIM, 16) results follow, each read from the
// accumulator memory in EMIT_RD and then loaded in EMIT_LD once the output register is free.
// Reset clears all control state; the B store is not cleared, and the accumulators need
// no clearing because the first element of every row overwrites them.
`default_nettype none

module matrix_multiply_row_stream_unit #(
    parameter int DIM = mmrs_pkg::DIM_DEFAULT
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // row_index[3:0], col_index[7:4], elem_value[23:8]
    input  wire logic [mmrs_pkg::S_DATA_BITS-1:0] s_tdata,
    // req_type
    input  wire logic                             s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // out_row[3:0], out_col[7:4], out_value[43:8], zero padding[47:44]
    output logic [mmrs_pkg::M_DATA_BITS-1:0]      m_tdata,
    // row_last
    output logic                                  m_tlast
);

    mmrs_pkg::cmd_t    cmd;
    mmrs_pkg::status_t status;

    mmrs_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    mmrs_datapath #(
        .DIM (DIM)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

// File: rtl/mmrs_ctrl.sv
// Controller state machine sequencing loads, MAC passes and row emission.
`default_nettype none

module mmrs_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire mmrs_pkg::status_t status,
    output mmrs_pkg::cmd_t         cmd
);

    mmrs_pkg::state_t state_reg;
    mmrs_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mmrs_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mmrs_pkg::ST_IDLE:
            begin
                if (status.a_start)
                begin
                    state_next = mmrs_pkg::ST_MAC;
                end
            end
            mmrs_pkg::ST_MAC:
            begin
                if (status.j_last)
                begin
                    state_next = mmrs_pkg::ST_DRAIN;
                end
            end
            mmrs_pkg::ST_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    state_next = status.emit_pending ? mmrs_pkg::ST_EMIT_RD
                                                     : mmrs_pkg::ST_IDLE;
                end
            end
            mmrs_pkg::ST_EMIT_RD:
            begin
                state_next = mmrs_pkg::ST_EMIT_LD;
            end
            mmrs_pkg::ST_EMIT_LD:
            begin
                if (status.out_free)
                begin
                    state_next = status.emit_last ? mmrs_pkg::ST_IDLE
                                                  : mmrs_pkg::ST_EMIT_RD;
                end
            end
            default:
            begin
                state_next = mmrs_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            mmrs_pkg::ST_IDLE:
            begin
                cmd.ready = 1'b1;
            end
            mmrs_pkg::ST_MAC:
            begin
                cmd.mac_issue = 1'b1;
            end
            mmrs_pkg::ST_EMIT_RD:
            begin
                cmd.emit_rd = 1'b1;
            end
            mmrs_pkg::ST_EMIT_LD:
            begin
                cmd.emit_ld = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/mmrs_datapath.sv
// Datapath with the B store, the accumulator memory, the shared MAC and the output register.
`default_nettype none

module mmrs_datapath #(
    parameter int DIM = mmrs_pkg::DIM_DEFAULT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire mmrs_pkg::cmd_t                      cmd,
    output mmrs_pkg::status_t                        status,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [mmrs_pkg::S_DATA_BITS-1:0]    s_tdata,
    input  wire logic                                s_tuser,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [mmrs_pkg::M_DATA_BITS-1:0]         m_tdata,
    output logic                                     m_tlast
);

    localparam int IDX_W  = $clog2(DIM);
    localparam int ADDR_W = $clog2(DIM * DIM);
    localparam int NOUT   = (DIM < mmrs_pkg::OUT_MAX) ? DIM : mmrs_pkg::OUT_MAX;
    localparam bit FULL   = (DIM >= (1 << mmrs_pkg::IDX_BITS));

    logic signed [mmrs_pkg::ELEM_BITS-1:0] b_mem [DIM*DIM];
    logic [mmrs_pkg::ACC_BITS-1:0]         acc_mem [DIM];

    logic [mmrs_pkg::IDX_BITS-1:0]         in_row;
    logic [mmrs_pkg::IDX_BITS-1:0]         in_col;
    logic signed [mmrs_pkg::ELEM_BITS-1:0] in_value;
    logic                                  in_range;
    logic                                  accept;
    logic                                  b_we;
    logic                                  a_start;
    logic [ADDR_W-1:0]                     b_wr_addr;
    logic [ADDR_W-1:0]                     b_rd_addr;

    logic signed [mmrs_pkg::ELEM_BITS-1:0] a_val_reg;
    logic [mmrs_pkg::IDX_BITS-1:0]         a_col_reg;
    logic                                  first_reg;
    logic [mmrs_pkg::IDX_BITS-1:0]         cur_row_reg;
    logic [IDX_W-1:0]                      elem_count_reg;
    logic                                  emit_pending_reg;
    logic [IDX_W-1:0]                      j_reg;
    logic                                  j_last;
    logic                                  emit_last;

    logic signed [mmrs_pkg::ELEM_BITS-1:0] b_q_reg;
    logic [mmrs_pkg::ACC_BITS-1:0]         acc_q_reg;
    logic                                  s1_v_reg;
    logic [IDX_W-1:0]                      s1_j_reg;
    logic                                  s1_first_reg;
    logic signed [mmrs_pkg::PROD_BITS-1:0] prod_reg;
    logic [mmrs_pkg::ACC_BITS-1:0]         acc_d_reg;
    logic                                  s2_v_reg;
    logic [IDX_W-1:0]                      s2_j_reg;
    logic                                  s2_first_reg;
    logic [mmrs_pkg::ACC_BITS-1:0]         acc_base;
    logic [mmrs_pkg::ACC_BITS-1:0]         acc_sum;

    logic                                  m_valid_reg;
    logic [mmrs_pkg::IDX_BITS-1:0]         out_row_reg;
    logic [mmrs_pkg::IDX_BITS-1:0]         out_col_reg;
    logic [mmrs_pkg::ACC_BITS-1:0]         out_value_reg;
    logic                                  row_last_reg;
    logic                                  out_free;

    assign in_row   = s_tdata[3:0];
    assign in_col   = s_tdata[7:4];
    assign in_value = s_tdata[23:8];
    assign in_range = FULL || ((in_row < mmrs_pkg::IDX_BITS'(DIM))
                               && (in_col < mmrs_pkg::IDX_BITS'(DIM)));

    assign s_tready = cmd.ready;
    assign accept   = s_tvalid && s_tready;
    assign b_we     = accept && in_range && (s_tuser == mmrs_pkg::REQ_LOAD_B);
    assign a_start  = accept && in_range && (s_tuser == mmrs_pkg::REQ_STREAM_A);

    assign b_wr_addr = ADDR_W'(in_row) * ADDR_W'(DIM) + ADDR_W'(in_col);
    assign b_rd_addr = ADDR_W'(a_col_reg) * ADDR_W'(DIM) + ADDR_W'(j_reg);

    assign j_last    = (j_reg == IDX_W'(DIM - 1));
    assign emit_last = (j_reg == IDX_W'(NOUT - 1));
    assign out_free  = !m_valid_reg || m_tready;

    assign status.a_start      = a_start;
    assign status.j_last       = j_last;
    assign status.pipe_busy    = s1_v_reg || s2_v_reg;
    assign status.emit_pending = emit_pending_reg;
    assign status.out_free     = out_free;
    assign status.emit_last    = emit_last;

    // The first element of a row starts from zero instead of the stored sum.
    assign acc_base = s2_first_reg ? '0 : acc_d_reg;
    assign acc_sum  = acc_base + {{(mmrs_pkg::ACC_BITS-mmrs_pkg::PROD_BITS){prod_reg[31]}},
                                  prod_reg};

    always_ff @(posedge clk)
    begin
        if (b_we)
        begin
            b_mem[b_wr_addr] <= in_value;
        end
        if (cmd.mac_issue)
        begin
            b_q_reg <= b_mem[b_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_v_reg)
        begin
            acc_mem[s2_j_reg] <= acc_sum;
        end
        if (cmd.mac_issue || cmd.emit_rd)
        begin
            acc_q_reg <= acc_mem[j_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_start)
        begin
            a_val_reg <= in_value;
            a_col_reg <= in_col;
            first_reg <= (elem_count_reg == '0);
        end
        s1_j_reg     <= j_reg;
        s1_first_reg <= first_reg;
        prod_reg     <= a_val_reg * b_q_reg;
        acc_d_reg    <= acc_q_reg;
        s2_j_reg     <= s1_j_reg;
        s2_first_reg <= s1_first_reg;
        if (cmd.emit_ld)
        begin
            out_row_reg   <= cur_row_reg;
            out_col_reg   <= mmrs_pkg::IDX_BITS'(j_reg);
            out_value_reg <= acc_q_reg;
            row_last_reg  <= emit_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_row_reg      <= '0;
            elem_count_reg   <= '0;
            emit_pending_reg <= 1'b0;
            j_reg            <= '0;
            s1_v_reg         <= 1'b0;
            s2_v_reg         <= 1'b0;
            m_valid_reg      <= 1'b0;
        end
        else
        begin
            s1_v_reg <= cmd.mac_issue;
            s2_v_reg <= s1_v_reg;
            if (a_start)
            begin
                if (elem_count_reg == '0)
                begin
                    cur_row_reg <= in_row;
                end
                if (elem_count_reg == IDX_W'(DIM - 1))
                begin
                    elem_count_reg   <= '0;
                    emit_pending_reg <= 1'b1;
                end
                else
                begin
                    elem_count_reg <= elem_count_reg + 1'b1;
                end
            end
            if (cmd.mac_issue)
            begin
                j_reg <= j_last ? '0 : j_reg + 1'b1;
            end
            else if (cmd.emit_ld)
            begin
                j_reg <= emit_last ? '0 : j_reg + 1'b1;
                if (emit_last)
                begin
                    emit_pending_reg <= 1'b0;
                end
            end
            if (cmd.emit_ld)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, out_value_reg, out_col_reg, out_row_reg};
    assign m_tlast  = row_last_reg;

    // Loads come only while the MAC pipeline is empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        b_we |-> (!s1_v_reg && !s2_v_reg))
        else $error("B store written while MAC pipeline busy");

    // A result is taken from the accumulators only after all writes are done.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_ld |-> (!s1_v_reg && !s2_v_reg))
        else $error("Result read before accumulator writes finished");

    // The row end marker sits on the last emitted column.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && row_last_reg) |-> (out_col_reg == mmrs_pkg::IDX_BITS'(NOUT - 1)))
        else $error("Row end marker on wrong column");

    // Completing a row restarts the element count and arms the emission.
    assert property (@(posedge clk) disable iff (!rst_n)
        (a_start && (elem_count_reg == IDX_W'(DIM - 1)))
        |=> ((elem_count_reg == '0) && emit_pending_reg))
        else $error("Row completion not recorded");

endmodule

`default_nettype wire

// File: verif/tb_matrix_multiply_row_stream_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for the streaming row-by-row matrix multiply unit.
module tb_matrix_multiply_row_stream_unit;

    localparam int DIM          = mmrs_pkg::DIM_DEFAULT;
    localparam int N_OUT        = (DIM < mmrs_pkg::OUT_MAX) ? DIM : mmrs_pkg::OUT_MAX;
    localparam int RAND_ITEMS   = 127;
    localparam int HOLD_AT      = 40;
    localparam int PAUSE_AT     = 90;
    localparam int HOLD_CYCLES  = 400;
    localparam int IDLE_LIMIT   = 3000;
    localparam int DRAIN_CYCLES = 60;
    localparam int MAX_REPORTS  = 10;
    localparam logic [mmrs_pkg::IDX_BITS-1:0] DIR_ROW = 4'd9;

    typedef struct packed {
        logic                           req;
        logic [mmrs_pkg::IDX_BITS-1:0]  row;
        logic [mmrs_pkg::IDX_BITS-1:0]  col;
        logic [mmrs_pkg::ELEM_BITS-1:0] value;
        logic                           typed;
    } elem_req_t;

    typedef struct packed {
        logic [mmrs_pkg::IDX_BITS-1:0]        row;
        logic [mmrs_pkg::IDX_BITS-1:0]        col;
        logic signed [mmrs_pkg::ACC_BITS-1:0] value;
        logic                                 last;
    } c_elem_t;

    logic                             clk;
    logic                             rst_n     = 1'b0;
    logic                             s_tvalid  = 1'b0;
    logic                             s_tready;
    logic [mmrs_pkg::S_DATA_BITS-1:0] s_tdata   = '0;
    logic                             s_tuser   = 1'b0;
    logic                             m_tvalid;
    logic                             m_tready  = 1'b0;
    logic [mmrs_pkg::M_DATA_BITS-1:0] m_tdata;
    logic                             m_tlast;
    logic                             dir_typed = 1'b0;

    logic signed [mmrs_pkg::ELEM_BITS-1:0] b_mat [0:DIM*DIM-1];
    logic [mmrs_pkg::ACC_BITS-1:0]         row_sum [0:DIM-1];
    int unsigned                           a_in_row = 0;
    logic [mmrs_pkg::IDX_BITS-1:0]         c_row = '0;
    c_elem_t                               pending_c [$];
    logic signed [mmrs_pkg::ACC_BITS-1:0]  dir_c_row [0:DIM-1];

    elem_req_t dir_items [$];
    bit        b_planned [0:DIM*DIM-1];
    bit        row_ready [0:DIM-1];
    bit        hold_req = 1'b0;
    bit        tx_burst = 1'b0;
    bit        rx_burst = 1'b0;

    int unsigned fail_cnt     = 0;
    int unsigned loads_seen   = 0;
    int unsigned elems_seen   = 0;
    int unsigned results_seen = 0;
    int unsigned rows_seen    = 0;
    int unsigned idle_cycles  = 0;

    matrix_multiply_row_stream_unit #(
        .DIM(DIM)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic flag_failure(input string msg);
        if (fail_cnt < MAX_REPORTS)
        begin
            $display("%s", msg);
        end
        fail_cnt++;
    endtask

    task automatic accumulate_element(input elem_req_t it);
        logic signed [2*mmrs_pkg::ELEM_BITS-1:0] prod;
        c_elem_t res;
        int j;
        if (it.req == mmrs_pkg::REQ_LOAD_B)
        begin
            b_mat[it.row*DIM + it.col] = it.value;
            loads_seen++;
        end
        else
        begin
            elems_seen++;
            if (a_in_row == 0)
            begin
                c_row = it.row;
            end
            for (j = 0; j < DIM; j++)
            begin
                prod = $signed(it.value) * b_mat[it.col*DIM + j];
                row_sum[j] = row_sum[j]
                             + {{(mmrs_pkg::ACC_BITS-2*mmrs_pkg::ELEM_BITS)
                                 {prod[2*mmrs_pkg::ELEM_BITS-1]}}, prod};
            end
            a_in_row++;
            if (a_in_row == DIM)
            begin
                for (j = 0; j < N_OUT; j++)
                begin
                    res.row   = it.typed ? DIR_ROW : c_row;
                    res.col   = j[mmrs_pkg::IDX_BITS-1:0];
                    res.value = it.typed ? dir_c_row[j] : row_sum[j];
                    res.last  = (j == N_OUT - 1);
                    pending_c.push_back(res);
                end
                for (j = 0; j < DIM; j++)
                begin
                    row_sum[j] = '0;
                end
                a_in_row = 0;
            end
        end
    endtask

    task automatic check_result(input c_elem_t got);
        c_elem_t want;
        results_seen++;
        if (got.last)
        begin
            rows_seen++;
        end
        if (pending_c.size() == 0)
        begin
            flag_failure($sformatf("Unexpected result: row %0d col %0d value %0d last %0b",
                                   got.row, got.col, $signed(got.value), got.last));
        end
        else
        begin
            want = pending_c.pop_front();
            if (got.row !== want.row || got.col !== want.col ||
                got.value !== want.value || got.last !== want.last)
            begin
                flag_failure($sformatf({"Mismatch: expected row %0d col %0d value %0d last %0b,",
                                        " got row %0d col %0d value %0d last %0b"},
                                       want.row, want.col, $signed(want.value), want.last,
                                       got.row, got.col, $signed(got.value), got.last));
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            accumulate_element({s_tuser, s_tdata[3:0], s_tdata[7:4], s_tdata[23:8], dir_typed});
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            check_result({m_tdata[3:0], m_tdata[7:4], m_tdata[43:8], m_tlast});
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin : result_sink
        int stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                rx_burst = !rx_burst;
            end
            stall = hold_req ? HOLD_CYCLES : (rx_burst ? 0 : $urandom_range(0, 18));
            hold_req = 1'b0;
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
            begin
                @(posedge clk);
            end
        end
    end

    task automatic add_item(input logic req, input logic [mmrs_pkg::IDX_BITS-1:0] row,
                            input logic [mmrs_pkg::IDX_BITS-1:0] col,
                            input logic [mmrs_pkg::ELEM_BITS-1:0] value,
                            input logic typed);
        dir_items.push_back({req, row, col, value, typed});
    endtask

    task automatic drive_item(input elem_req_t it);
        int gap;
        int k;
        if (it.req == mmrs_pkg::REQ_LOAD_B)
        begin
            b_planned[it.row*DIM + it.col] = 1'b1;
            row_ready[it.row] = 1'b1;
            for (k = 0; k < DIM; k++)
            begin
                if (!b_planned[it.row*DIM + k])
                begin
                    row_ready[it.row] = 1'b0;
                end
            end
        end
        if ($urandom_range(0, 19) == 0)
        begin
            tx_burst = !tx_burst;
        end
        gap = tx_burst ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid  <= 1'b1;
        s_tuser   <= it.req;
        s_tdata   <= {it.value, it.col, it.row};
        dir_typed <= it.typed;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin : stimulus
        elem_req_t                     it;
        int                            ready_rows [$];
        int                            n;
        int                            r;
        int                            p;
        int                            fill_col;
        logic [mmrs_pkg::IDX_BITS-1:0] fill_row;

        for (r = 0; r < DIM; r++)
        begin
            row_sum[r] = '0;
        end

        // B row 0 holds the extremes; the last column is written again in the middle of the row.
        add_item(mmrs_pkg::REQ_LOAD_B,   4'd0,  4'd0,  16'h8000, 1'b0);
        add_item(mmrs_pkg::REQ_LOAD_B,   4'd0,  4'd1,  16'h7FFF, 1'b0);
        add_item(mmrs_pkg::REQ_LOAD_B,   4'd0,  4'd2,  16'h0000, 1'b0);
        add_item(mmrs_pkg::REQ_LOAD_B,   4'd0,  4'd3,  16'hFFFF, 1'b0);
        add_item(mmrs_pkg::REQ_LOAD_B,   4'd0,  4'd4,  16'h0001, 1'b0);
        add_item(mmrs_pkg::REQ_LOAD_B,   4'd0,  4'd5,  16'h0100, 1'b0);
        add_item(mmrs_pkg::REQ_LOAD_B,   4'd0,  4'd6,  16'hFF00, 1'b0);
        add_item(mmrs_pkg::REQ_LOAD_B,   4'd0,  4'd7,  16'h5555, 1'b0);
        add_item(mmrs_pkg::REQ_LOAD_B,   4'd0,  4'd8,  16'hAAAA, 1'b0);
        add_item(mmrs_pkg::REQ_LOAD_B,   4'd0,  4'd9,  16'h0002, 1'b0);
        add_item(mmrs_pkg::REQ_LOAD_B,   4'd0,  4'd10, 16'h0004, 1'b0);
        add_item(mmrs_pkg::REQ_LOAD_B,   4'd0,  4'd11, 16'h0008, 1'b0);
        add_item(mmrs_pkg::REQ_LOAD_B,   4'd0,  4'd12, 16'h0010, 1'b0);
        add_item(mmrs_pkg::REQ_LOAD_B,   4'd0,  4'd13, 16'h0020, 1'b0);
        add_item(mmrs_pkg::REQ_LOAD_B,   4'd0,  4'd14, 16'h0040, 1'b0);
        add_item(mmrs_pkg::REQ_LOAD_B,   4'd0,  4'd15, 16'h0000, 1'b0);
        // Only the first row tag of the row counts; later ones differ on purpose.
        add_item(mmrs_pkg::REQ_STREAM_A, DIR_ROW, 4'd0, 16'h8000, 1'b0);
        add_item(mmrs_pkg::REQ_STREAM_A, 4'd3,  4'd0,  16'h8000, 1'b0);
        add_item(mmrs_pkg::REQ_STREAM_A, 4'd15, 4'd0,  16'h8000, 1'b0);
        add_item(mmrs_pkg::REQ_STREAM_A, 4'd0,  4'd0,  16'h8000, 1'b0);
        add_item(mmrs_pkg::REQ_STREAM_A, 4'd6,  4'd0,  16'h8000, 1'b0);
        add_item(mmrs_pkg::REQ_STREAM_A, 4'd12, 4'd0,  16'h8000, 1'b0);
        add_item(mmrs_pkg::REQ_STREAM_A, 4'd5,  4'd0,  16'h8000, 1'b0);
        add_item(mmrs_pkg::REQ_STREAM_A, 4'd10, 4'd0,  16'h8000, 1'b0);
        add_item(mmrs_pkg::REQ_LOAD_B,   4'd0,  4'd15, 16'h0001, 1'b0);
        add_item(mmrs_pkg::REQ_STREAM_A, 4'd1,  4'd0,  16'h8000, 1'b0);
        add_item(mmrs_pkg::REQ_STREAM_A, 4'd14, 4'd0,  16'h8000, 1'b0);
        add_item(mmrs_pkg::REQ_STREAM_A, 4'd2,  4'd0,  16'h8000, 1'b0);
        add_item(mmrs_pkg::REQ_STREAM_A, 4'd13, 4'd0,  16'h8000, 1'b0);
        add_item(mmrs_pkg::REQ_STREAM_A, 4'd4,  4'd0,  16'h8000, 1'b0);
        add_item(mmrs_pkg::REQ_STREAM_A, 4'd11, 4'd0,  16'h8000, 1'b0);
        add_item(mmrs_pkg::REQ_STREAM_A, 4'd7,  4'd0,  16'h8000, 1'b0);
        add_item(mmrs_pkg::REQ_STREAM_A, 4'd8,  4'd0,  16'h8000, 1'b1);

        // Every A element is the most negative value, so each column is -524288 times the
        // raw B[0][j]; the last column only sees the second half of the row.
        dir_c_row[0]  =  36'sd17179869184;
        dir_c_row[1]  = -36'sd17179344896;
        dir_c_row[2]  =  36'sd0;
        dir_c_row[3]  =  36'sd524288;
        dir_c_row[4]  = -36'sd524288;
        dir_c_row[5]  = -36'sd134217728;
        dir_c_row[6]  =  36'sd134217728;
        dir_c_row[7]  = -36'sd11453071360;
        dir_c_row[8]  =  36'sd11453595648;
        dir_c_row[9]  = -36'sd1048576;
        dir_c_row[10] = -36'sd2097152;
        dir_c_row[11] = -36'sd4194304;
        dir_c_row[12] = -36'sd8388608;
        dir_c_row[13] = -36'sd16777216;
        dir_c_row[14] = -36'sd33554432;
        dir_c_row[15] = -36'sd262144;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_items[i])
        begin
            drive_item(dir_items[i]);
        end

        // Random part: B rows are filled one after another so A only reads loaded rows.
        fill_row = 4'd15;
        fill_col = 0;
        for (n = 0; n < RAND_ITEMS; n++)
        begin
            if (n == HOLD_AT)
            begin
                hold_req = 1'b1;
            end
            if (n == PAUSE_AT)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
                while (pending_c.size() != 0)
                begin
                    @(posedge clk);
                end
            end
            it = '0;
            case ($urandom_range(0, 9))
                0:       it.value = 16'h8000;
                1:       it.value = 16'h7FFF;
                2:       it.value = 16'hFFFF;
                default: it.value = mmrs_pkg::ELEM_BITS'($urandom);
            endcase
            p = $urandom_range(0, 99);
            if (p < 30)
            begin
                it.req = mmrs_pkg::REQ_LOAD_B;
                if ($urandom_range(0, 3) != 0)
                begin
                    it.row = fill_row;
                    it.col = mmrs_pkg::IDX_BITS'(fill_col);
                    fill_col++;
                    if (fill_col == DIM)
                    begin
                        fill_row = mmrs_pkg::IDX_BITS'($urandom_range(0, DIM - 1));
                        fill_col = 0;
                    end
                end
                else
                begin
                    it.row = mmrs_pkg::IDX_BITS'($urandom_range(0, DIM - 1));
                    it.col = mmrs_pkg::IDX_BITS'($urandom_range(0, DIM - 1));
                end
            end
            else
            begin
                it.req = mmrs_pkg::REQ_STREAM_A;
                it.row = mmrs_pkg::IDX_BITS'($urandom_range(0, DIM - 1));
                ready_rows.delete();
                for (r = 0; r < DIM; r++)
                begin
                    if (row_ready[r])
                    begin
                        ready_rows.push_back(r);
                    end
                end
                it.col = mmrs_pkg::IDX_BITS'(ready_rows[$urandom_range(0, ready_rows.size() - 1)]);
            end
            drive_item(it);
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_c.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d B loads and %0d A elements with random gaps, a long output stall",
                 loads_seen, elems_seen);
        $display("and a drain pause; compared %0d C results in %0d rows, %0d failures.",
                 results_seen, rows_seen, fail_cnt);
        if (fail_cnt == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/mmrs_pkg.sv
rtl/mmrs_ctrl.sv
rtl/mmrs_datapath.sv
rtl/matrix_multiply_row_stream_unit.sv
verif/tb_matrix_multiply_row_stream_unit.sv
